>>> rtl/core/mpeg_audio_header_decoder_assert.svh
// ----------------------------------------------------------------------------
// MPEG audio header decoder assertion macros
// Concurrent checks clocked on clk, disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef MPEG_AUDIO_HEADER_DECODER_ASSERT_SVH
`define MPEG_AUDIO_HEADER_DECODER_ASSERT_SVH

// same-cycle implication
`define MAHD_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define MAHD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/core/mahd_pkg.sv
// ----------------------------------------------------------------------------
// mahd_pkg
// Types, codes and fixed tables shared by the MPEG audio header decoder.
// ----------------------------------------------------------------------------
package mahd_pkg;

	localparam logic [11:0] SYNC_WORD = 12'hfff;

	localparam logic [2:0] ST_OK          = 3'd0;
	localparam logic [2:0] ST_NO_SYNC     = 3'd1;
	localparam logic [2:0] ST_RES_LAYER   = 3'd2;
	localparam logic [2:0] ST_RES_RATE    = 3'd3;
	localparam logic [2:0] ST_BAD_BITRATE = 3'd4;

	// header layer bits
	localparam logic [1:0] LB_RESERVED = 2'd0;
	localparam logic [1:0] LB_LAYER3   = 2'd1;
	localparam logic [1:0] LB_LAYER1   = 2'd3;

	localparam logic [1:0] SR_44100    = 2'd0;
	localparam logic [1:0] SR_48000    = 2'd1;
	localparam logic [1:0] SR_32000    = 2'd2;
	localparam logic [1:0] SR_RESERVED = 2'd3;

	localparam logic [1:0] MODE_JOINT  = 2'd1;
	localparam logic [1:0] MODE_MONO   = 2'd3;

	localparam logic [3:0] BRI_BAD     = 4'd15;

	// 44.1 kHz: frame length = floor(k * kbps / 441), k = 120 (layer I) or 1440
	localparam logic [10:0] MULT_L1    = 11'd120;
	localparam logic [10:0] MULT_L23   = 11'd1440;
	localparam logic [19:0] DIV_441    = 20'd441;
	localparam logic [11:0] RECIP_441  = 12'd2377;   // floor(2^20 / 441)

	localparam logic [5:0] SUBBANDS    = 6'd32;

	localparam logic [8:0] BITRATE_KBPS [48] = '{
		9'd0, 9'd32, 9'd64, 9'd96, 9'd128, 9'd160, 9'd192, 9'd224,
		9'd256, 9'd288, 9'd320, 9'd352, 9'd384, 9'd416, 9'd448, 9'd0,
		9'd0, 9'd32, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96, 9'd112,
		9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320, 9'd384, 9'd0,
		9'd0, 9'd32, 9'd40, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96,
		9'd112, 9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320, 9'd0
	};

	localparam logic [5:0] JBOUND_L12 [4] = '{6'd4, 6'd8, 6'd12, 6'd16};
	localparam logic [5:0] JBOUND_L3  [4] = '{6'd0, 6'd4, 6'd8, 6'd16};

	typedef struct packed {
		logic [7:0] data_byte;
		logic       frame_start;
	} item_t;

	typedef struct packed {
		logic [2:0]  status;
		logic        version;
		logic [2:0]  layer;
		logic [3:0]  bitrate_code;
		logic [1:0]  sample_rate_index;
		logic [1:0]  channel_mode;
		logic [1:0]  mode_extension;
		logic [4:0]  header_flags;
		logic [1:0]  emphasis;
		logic [10:0] frame_bytes;
		logic [1:0]  channels;
		logic [5:0]  joint_bound;
	} result_t;

	typedef struct packed {
		logic load_first;
		logic shift_in;
		logic load_header;
		logic mul_step;
		logic recip_step;
		logic finish;
	} cmd_t;

	function automatic logic [8:0] bitrate_kbps(input logic [1:0] layer_bits,
			input logic [3:0] index);
		logic [1:0] row;
		row = 2'(2'd3 - layer_bits);
		if (layer_bits == LB_RESERVED) begin
			return 9'd0;
		end
		return BITRATE_KBPS[{row, index}];
	endfunction

endpackage

>>> rtl/core/mahd_ctrl.sv
// ----------------------------------------------------------------------------
// mahd_ctrl
// Byte counting and sequencing of the frame length computation.
// ----------------------------------------------------------------------------
module mahd_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	input  logic              frame_start,
	output logic              item_stall,
	input  logic              result_stall,
	output logic              result_valid,
	output mahd_pkg::cmd_t    cmd
);

	typedef enum logic [3:0] {
		COLLECT = 4'b0001,
		CALC1   = 4'b0010,
		CALC2   = 4'b0100,
		CALC3   = 4'b1000
	} state_t;

	state_t     state_q, state_d;
	logic [1:0] byte_count_q, byte_count_d;
	logic       out_valid_q;
	logic       accept;
	logic       slot_free;

	assign item_stall   = (state_q != COLLECT);
	assign accept       = item_valid && !item_stall;
	assign slot_free    = !out_valid_q || !result_stall;
	assign result_valid = out_valid_q;

	always_comb begin
		state_d      = state_q;
		byte_count_d = byte_count_q;
		cmd          = '0;
		unique case (state_q)
			COLLECT: begin
				if (accept) begin
					if (frame_start) begin
						cmd.load_first = 1'b1;
						byte_count_d   = 2'd1;
					end else if (byte_count_q == 2'd3) begin
						cmd.load_header = 1'b1;
						byte_count_d    = 2'd0;
						state_d         = CALC1;
					end else if (byte_count_q != 2'd0) begin
						cmd.shift_in = 1'b1;
						byte_count_d = byte_count_q + 2'd1;
					end
				end
			end
			CALC1: begin
				cmd.mul_step = 1'b1;
				state_d      = CALC2;
			end
			CALC2: begin
				cmd.recip_step = 1'b1;
				state_d        = CALC3;
			end
			CALC3: begin
				if (slot_free) begin
					cmd.finish = 1'b1;
					state_d    = COLLECT;
				end
			end
			default: begin
				state_d = COLLECT;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= COLLECT;
			byte_count_q <= 2'd0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q      <= state_d;
			byte_count_q <= byte_count_d;
			if (cmd.finish) begin
				out_valid_q <= 1'b1;
			end else if (!result_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

>>> rtl/core/mahd_dp.sv
// ----------------------------------------------------------------------------
// mahd_dp
// Header shift register, field split, frame length arithmetic, result register.
// ----------------------------------------------------------------------------
module mahd_dp (
	input  logic              clk,
	input  mahd_pkg::item_t   item,
	input  mahd_pkg::cmd_t    cmd,
	output mahd_pkg::result_t result
);

	logic [23:0]       shift_q;
	logic [31:0]       header_q;
	logic [8:0]        kbps_q;
	logic [19:0]       n_q;
	logic [10:0]       q0_q;
	mahd_pkg::result_t result_q;

	logic        sync_ok;
	logic        version;
	logic [1:0]  lbits;
	logic        prot;
	logic [3:0]  bri;
	logic [1:0]  sri;
	logic        pad;
	logic        priv;
	logic [1:0]  mode;
	logic [1:0]  mext;
	logic        copy;
	logic        orig;
	logic [1:0]  emph;
	logic        is_l1;

	logic [8:0]  kbps;
	logic [10:0] mult;
	logic [31:0] prod;
	logic [19:0] rem;
	logic [10:0] q44;
	logic [10:0] k3;
	logic [11:0] k9;
	logic [10:0] quot;
	logic [10:0] flen;
	logic [2:0]  status;
	logic [5:0]  jbound;
	mahd_pkg::result_t res_d;

	assign sync_ok = (header_q[31:20] == mahd_pkg::SYNC_WORD);
	assign version = header_q[19];
	assign lbits   = header_q[18:17];
	assign prot    = header_q[16];
	assign bri     = header_q[15:12];
	assign sri     = header_q[11:10];
	assign pad     = header_q[9];
	assign priv    = header_q[8];
	assign mode    = header_q[7:6];
	assign mext    = header_q[5:4];
	assign copy    = header_q[3];
	assign orig    = header_q[2];
	assign emph    = header_q[1:0];
	assign is_l1   = (lbits == mahd_pkg::LB_LAYER1);

	assign kbps = mahd_pkg::bitrate_kbps(lbits, bri);
	assign mult = is_l1 ? mahd_pkg::MULT_L1 : mahd_pkg::MULT_L23;
	assign prod = 32'(n_q) * 32'(mahd_pkg::RECIP_441);

	// reciprocal estimate is at most one low
	assign rem = n_q - 20'(q0_q) * mahd_pkg::DIV_441;
	assign q44 = q0_q + 11'(rem >= mahd_pkg::DIV_441);
	assign k3  = 11'(kbps_q) * 11'd3;
	assign k9  = 12'(kbps_q) * 12'd9;

	always_comb begin
		unique case (sri)
			mahd_pkg::SR_44100: quot = q44;
			mahd_pkg::SR_48000: quot = is_l1 ? 11'(kbps_q >> 2) : k3;
			mahd_pkg::SR_32000: quot = is_l1 ? (k3 >> 3) : 11'(k9 >> 1);
			default:            quot = 11'd0;
		endcase
	end

	always_comb begin
		priority if (!sync_ok) begin
			status = mahd_pkg::ST_NO_SYNC;
		end else if (lbits == mahd_pkg::LB_RESERVED) begin
			status = mahd_pkg::ST_RES_LAYER;
		end else if (sri == mahd_pkg::SR_RESERVED) begin
			status = mahd_pkg::ST_RES_RATE;
		end else if (bri == mahd_pkg::BRI_BAD) begin
			status = mahd_pkg::ST_BAD_BITRATE;
		end else begin
			status = mahd_pkg::ST_OK;
		end
	end

	always_comb begin
		if (status != mahd_pkg::ST_OK) begin
			flen = 11'd0;
		end else if (is_l1) begin
			flen = 11'({quot + 11'(pad), 2'b00});
		end else begin
			flen = quot + 11'(pad);
		end
	end

	always_comb begin
		if (mode == mahd_pkg::MODE_JOINT && lbits != mahd_pkg::LB_RESERVED) begin
			jbound = (lbits == mahd_pkg::LB_LAYER3) ? mahd_pkg::JBOUND_L3[mext]
				: mahd_pkg::JBOUND_L12[mext];
		end else begin
			jbound = mahd_pkg::SUBBANDS;
		end
	end

	always_comb begin
		res_d = '0;
		if (!sync_ok) begin
			res_d.status = mahd_pkg::ST_NO_SYNC;
		end else begin
			res_d.status            = status;
			res_d.version           = version;
			res_d.layer             = 3'd4 - 3'(lbits);
			res_d.bitrate_code      = bri;
			res_d.sample_rate_index = sri;
			res_d.channel_mode      = mode;
			res_d.mode_extension    = mext;
			res_d.header_flags      = {pad, orig, copy, priv, ~prot};
			res_d.emphasis          = emph;
			res_d.frame_bytes       = flen;
			res_d.channels          = (mode == mahd_pkg::MODE_MONO) ? 2'd1 : 2'd2;
			res_d.joint_bound       = jbound;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_first) begin
			shift_q <= {16'd0, item.data_byte};
		end else if (cmd.shift_in) begin
			shift_q <= {shift_q[15:0], item.data_byte};
		end
		if (cmd.load_header) begin
			header_q <= {shift_q, item.data_byte};
		end
		if (cmd.mul_step) begin
			kbps_q <= kbps;
			n_q    <= 20'(kbps) * 20'(mult);
		end
		if (cmd.recip_step) begin
			q0_q <= prod[30:20];
		end
		if (cmd.finish) begin
			result_q <= res_d;
		end
	end

	assign result = result_q;

endmodule

>>> rtl/core/mpeg_audio_header_decoder.sv
// ----------------------------------------------------------------------------
// mpeg_audio_header_decoder
// MPEG-1 audio frame header parser: sync check, field split, frame length.
// ----------------------------------------------------------------------------
// Feed the four header bytes most significant first, the first with
// frame_start set; frame_start restarts the count at any byte, and bytes
// without a header in progress are dropped. Each byte takes one beat. After
// the fourth byte the input stalls while the frame length is worked out in
// the shared arithmetic path (table multiply, reciprocal multiply by 1/441,
// one correction step); the correction step is held for as long as a
// previous result still waits in the output register.
module mpeg_audio_header_decoder (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_stall,
	input  mahd_pkg::item_t   item,
	output logic              result_valid,
	input  logic              result_stall,
	output mahd_pkg::result_t result
);

	mahd_pkg::cmd_t cmd;

	mahd_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.frame_start  (item.frame_start),
		.item_stall   (item_stall),
		.result_stall (result_stall),
		.result_valid (result_valid),
		.cmd          (cmd)
	);

	mahd_dp u_dp (
		.clk    (clk),
		.item   (item),
		.cmd    (cmd),
		.result (result)
	);

`include "mpeg_audio_header_decoder_assert.svh"

	`MAHD_ASSERT_NEXT(a_stall_after_header, cmd.load_header, item_stall, "input open during calc")
	`MAHD_ASSERT_NOW(a_no_overwrite, cmd.finish, !result_valid || !result_stall, "result overwritten")
	`MAHD_ASSERT_NEXT(a_finish_valid, cmd.finish, result_valid, "finished result not shown")

endmodule

>>> tb/sv/mpeg_audio_header_decoder_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpeg_audio_header_decoder_test
// Self-checking bench for the MPEG-1 audio frame header decoder. A short
// table of header bytes covers the extremes and error codes, then random
// headers, broken headers and stray bytes follow. Every decoded header is
// checked field by field against its table row or a cycle-free parser
// model, under random idling on both sides and one long output hold-off.
// ----------------------------------------------------------------------------
module mpeg_audio_header_decoder_test;

	localparam int CYCLE_LIMIT  = 300000;
	localparam int RANDOM_BEATS = 1650;
	localparam int TAIL_BEATS   = 150;
	localparam int DRAIN_CYCLES = 20;
	localparam int BACKLOG_AT   = 400;
	localparam int BACKLOG_LEN  = 300;

	localparam logic [1:0] MODE_STEREO = 2'd0;

	localparam int unsigned KBPS_BY_LAYER [3][16] = '{
		'{0, 32, 64, 96, 128, 160, 192, 224, 256, 288, 320, 352, 384, 416, 448, 0},
		'{0, 32, 48, 56, 64, 80, 96, 112, 128, 160, 192, 224, 256, 320, 384, 0},
		'{0, 32, 40, 48, 56, 64, 80, 96, 112, 128, 160, 192, 224, 256, 320, 0}
	};
	localparam int unsigned RATE_HZ [3] = '{44100, 48000, 32000};
	localparam logic [5:0] BOUND_I_II  [4] = '{6'd4, 6'd8, 6'd12, 6'd16};
	localparam logic [5:0] BOUND_III   [4] = '{6'd0, 6'd4, 6'd8, 6'd16};

	typedef struct packed {
		logic [7:0]        data;
		logic              start;
		logic              typed;
		mahd_pkg::result_t want;
	} row_t;

	localparam mahd_pkg::result_t NO_RESULT   = '0;
	localparam mahd_pkg::result_t R_LONGEST   = '{mahd_pkg::ST_OK, 1'b1, 3'd2, 4'd14,
		mahd_pkg::SR_32000, mahd_pkg::MODE_JOINT, 2'd3, 5'b11110, 2'd3, 11'd1729, 2'd2,
		6'd16};
	localparam mahd_pkg::result_t R_NO_SYNC   = '{mahd_pkg::ST_NO_SYNC, 1'b0, 3'd0, 4'd0,
		2'd0, 2'd0, 2'd0, 5'd0, 2'd0, 11'd0, 2'd0, 6'd0};
	localparam mahd_pkg::result_t R_RES_LAYER = '{mahd_pkg::ST_RES_LAYER, 1'b0, 3'd4, 4'd0,
		mahd_pkg::SR_44100, mahd_pkg::MODE_JOINT, 2'd3, 5'b00001, 2'd0, 11'd0, 2'd2,
		mahd_pkg::SUBBANDS};
	localparam mahd_pkg::result_t R_RES_RATE  = '{mahd_pkg::ST_RES_RATE, 1'b1, 3'd1,
		mahd_pkg::BRI_BAD, mahd_pkg::SR_RESERVED, mahd_pkg::MODE_MONO, 2'd0, 5'd0, 2'd0,
		11'd0, 2'd1, mahd_pkg::SUBBANDS};
	localparam mahd_pkg::result_t R_BAD_RATE  = '{mahd_pkg::ST_BAD_BITRATE, 1'b1, 3'd1,
		mahd_pkg::BRI_BAD, mahd_pkg::SR_44100, MODE_STEREO, 2'd0, 5'b00001, 2'd0, 11'd0,
		2'd2, mahd_pkg::SUBBANDS};

	localparam row_t DIRECTED [27] = '{
		'{8'hFF, 1'b0, 1'b0, NO_RESULT},	// stray byte while idle
		'{8'hFF, 1'b1, 1'b0, NO_RESULT},	// layer II, 384 kbps, 32 kHz, padded
		'{8'hFD, 1'b0, 1'b0, NO_RESULT},
		'{8'hEB, 1'b0, 1'b0, NO_RESULT},
		'{8'h7F, 1'b0, 1'b1, R_LONGEST},
		'{8'hFF, 1'b1, 1'b0, NO_RESULT},	// restart after two bytes
		'{8'hE2, 1'b0, 1'b0, NO_RESULT},
		'{8'hFF, 1'b1, 1'b0, NO_RESULT},	// MPEG-2 bit, layer I, free format
		'{8'hF7, 1'b0, 1'b0, NO_RESULT},
		'{8'h02, 1'b0, 1'b0, NO_RESULT},
		'{8'h44, 1'b0, 1'b0, NO_RESULT},
		'{8'h12, 1'b1, 1'b0, NO_RESULT},	// no sync
		'{8'h34, 1'b0, 1'b0, NO_RESULT},
		'{8'h56, 1'b0, 1'b0, NO_RESULT},
		'{8'h78, 1'b0, 1'b1, R_NO_SYNC},
		'{8'hFF, 1'b1, 1'b0, NO_RESULT},	// reserved layer, joint stereo
		'{8'hF0, 1'b0, 1'b0, NO_RESULT},
		'{8'h00, 1'b0, 1'b0, NO_RESULT},
		'{8'h70, 1'b0, 1'b1, R_RES_LAYER},
		'{8'hFF, 1'b1, 1'b0, NO_RESULT},	// reserved rate wins over bitrate 15
		'{8'hFF, 1'b0, 1'b0, NO_RESULT},
		'{8'hFC, 1'b0, 1'b0, NO_RESULT},
		'{8'hC0, 1'b0, 1'b1, R_RES_RATE},
		'{8'hFF, 1'b1, 1'b0, NO_RESULT},	// bitrate 15
		'{8'hFE, 1'b0, 1'b0, NO_RESULT},
		'{8'hF0, 1'b0, 1'b0, NO_RESULT},
		'{8'h00, 1'b0, 1'b1, R_BAD_RATE}
	};

	logic              clk = 1'b0;
	logic              arst_n;
	logic              item_valid;
	logic              item_stall;
	mahd_pkg::item_t   item;
	logic              result_valid;
	logic              result_stall;
	mahd_pkg::result_t result;

	row_t              stim [$];
	mahd_pkg::result_t decoded [$];
	logic [2:0]        byte_cnt;
	logic [23:0]       hdr_bytes;
	int                beats_in;
	int                headers_checked;
	int                error_headers;
	int                mismatches;
	int                cycle_count;
	int                idle_level;
	bit                tail;
	bit                backlog_done;

	mpeg_audio_header_decoder uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic mahd_pkg::result_t predict_header(input logic [31:0] h);
		mahd_pkg::result_t r;
		logic [1:0]        lbits;
		int unsigned       kbps;
		int unsigned       fs;
		int unsigned       len;
		r = '0;
		if (h[31:20] != mahd_pkg::SYNC_WORD) begin
			r.status = mahd_pkg::ST_NO_SYNC;
			return r;
		end
		lbits                = h[18:17];
		r.version            = h[19];
		r.layer              = 3'd4 - 3'(lbits);
		r.bitrate_code       = h[15:12];
		r.sample_rate_index  = h[11:10];
		r.channel_mode       = h[7:6];
		r.mode_extension     = h[5:4];
		r.header_flags       = {h[9], h[2], h[3], h[8], ~h[16]};
		r.emphasis           = h[1:0];
		if (lbits == mahd_pkg::LB_RESERVED) begin
			r.status = mahd_pkg::ST_RES_LAYER;
		end else if (h[11:10] == mahd_pkg::SR_RESERVED) begin
			r.status = mahd_pkg::ST_RES_RATE;
		end else if (h[15:12] == mahd_pkg::BRI_BAD) begin
			r.status = mahd_pkg::ST_BAD_BITRATE;
		end else begin
			r.status = mahd_pkg::ST_OK;
		end
		if (r.status == mahd_pkg::ST_OK) begin
			kbps = KBPS_BY_LAYER[r.layer - 3'd1][h[15:12]];
			fs = RATE_HZ[h[11:10]];
			if (lbits == mahd_pkg::LB_LAYER1) begin
				len = (12 * kbps * 1000 / fs + h[9]) * 4;
			end else begin
				len = 144 * kbps * 1000 / fs + h[9];
			end
			r.frame_bytes = len[10:0];
		end
		r.channels = (r.channel_mode == mahd_pkg::MODE_MONO) ? 2'd1 : 2'd2;
		if (r.channel_mode == mahd_pkg::MODE_JOINT && lbits != mahd_pkg::LB_RESERVED) begin
			r.joint_bound = (lbits == mahd_pkg::LB_LAYER3) ? BOUND_III[h[5:4]]
				: BOUND_I_II[h[5:4]];
		end else begin
			r.joint_bound = mahd_pkg::SUBBANDS;
		end
		return r;
	endfunction

	// returns 1 when the beat completes a header
	function automatic bit take_byte(input logic [7:0] b, input logic s,
			output mahd_pkg::result_t r);
		r = '0;
		if (s) begin
			hdr_bytes = {16'd0, b};
			byte_cnt = 3'd1;
			return 1'b0;
		end
		if (byte_cnt == 3'd0) begin
			return 1'b0;
		end
		if (byte_cnt < 3'd3) begin
			hdr_bytes = {hdr_bytes[15:0], b};
			byte_cnt = byte_cnt + 3'd1;
			return 1'b0;
		end
		r = predict_header({hdr_bytes, b});
		byte_cnt = 3'd0;
		return 1'b1;
	endfunction

	task automatic add_beat(input logic [7:0] b, input logic s);
		stim.push_back('{b, s, 1'b0, NO_RESULT});
	endtask

	task automatic compare_field(input string name, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			$display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("%0t ns: timeout, %0d headers still expected", $time, decoded.size());
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	always @(posedge clk) begin : check_results
		mahd_pkg::result_t oldest;
		if (arst_n && result_valid && !result_stall) begin
			if (decoded.size() == 0) begin
				$display("%0t ns: unexpected result, expected none, got %p", $time, result);
				mismatches++;
			end else begin
				oldest = decoded.pop_front();
				headers_checked++;
				if (oldest.status != mahd_pkg::ST_OK) begin
					error_headers++;
				end
				compare_field("status", oldest.status, result.status);
				compare_field("version", oldest.version, result.version);
				compare_field("layer", oldest.layer, result.layer);
				compare_field("bitrate_code", oldest.bitrate_code, result.bitrate_code);
				compare_field("sample_rate_index", oldest.sample_rate_index,
					result.sample_rate_index);
				compare_field("channel_mode", oldest.channel_mode, result.channel_mode);
				compare_field("mode_extension", oldest.mode_extension, result.mode_extension);
				compare_field("header_flags", oldest.header_flags, result.header_flags);
				compare_field("emphasis", oldest.emphasis, result.emphasis);
				compare_field("frame_bytes", oldest.frame_bytes, result.frame_bytes);
				compare_field("channels", oldest.channels, result.channels);
				compare_field("joint_bound", oldest.joint_bound, result.joint_bound);
			end
		end
	end

	// output side: random stall bursts plus one long hold-off to back up the input
	initial begin
		result_stall <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (!backlog_done && beats_in >= BACKLOG_AT) begin
				backlog_done = 1'b1;
				result_stall <= 1'b1;
				repeat (BACKLOG_LEN) @(posedge clk);
				result_stall <= 1'b0;
			end else if (!tail && idle_level != 0 && $urandom_range(0, 7) < idle_level) begin
				result_stall <= 1'b1;
				repeat ($urandom_range(1, 9)) @(posedge clk);
				result_stall <= 1'b0;
			end
		end
	end

	initial begin
		int                kind;
		int                len;
		int                counted;
		mahd_pkg::result_t predicted;
		arst_n <= 1'b0;
		item_valid <= 1'b0;
		item <= '0;
		byte_cnt = 3'd0;
		hdr_bytes = '0;
		beats_in = 0;
		headers_checked = 0;
		error_headers = 0;
		mismatches = 0;
		cycle_count = 0;
		idle_level = 0;
		tail = 1'b0;
		backlog_done = 1'b0;

		foreach (DIRECTED[i]) begin
			stim.push_back(DIRECTED[i]);
		end
		counted = 0;
		while (counted < RANDOM_BEATS) begin
			kind = $urandom_range(0, 15);
			if (kind < 11) begin
				// sync-led header, random content
				add_beat(8'hFF, 1'b1);
				add_beat((kind == 10) ? 8'($urandom) : {4'hF, 4'($urandom)}, 1'b0);
				add_beat(8'($urandom), 1'b0);
				add_beat(8'($urandom), 1'b0);
				counted += 4;
			end else if (kind < 13) begin
				add_beat(8'($urandom), 1'b1);
				repeat (3) add_beat(8'($urandom), 1'b0);
				counted += 4;
			end else if (kind == 13) begin
				// cut short, the next start restarts it
				len = $urandom_range(0, 2);
				add_beat(8'hFF, 1'b1);
				repeat (len) add_beat(8'($urandom), 1'b0);
				counted += len + 1;
			end else begin
				len = $urandom_range(1, 4);
				repeat (len) add_beat(8'($urandom), $urandom_range(0, 3) == 0);
				counted += len;
			end
		end

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		for (int i = 0; i < stim.size(); i++) begin
			if (i % 64 == 0) begin
				idle_level = $urandom_range(0, 3);
			end
			tail = (stim.size() - i) < TAIL_BEATS;
			if (!tail && idle_level != 0 && $urandom_range(0, 7) < idle_level) begin
				item_valid <= 1'b0;
				repeat ($urandom_range(1, 9)) @(posedge clk);
			end
			item_valid <= 1'b1;
			item <= {stim[i].data, stim[i].start};
			@(posedge clk);
			while (item_stall) @(posedge clk);
			beats_in++;
			if (take_byte(stim[i].data, stim[i].start, predicted)) begin
				decoded.push_back(stim[i].typed ? stim[i].want : predicted);
			end
		end
		item_valid <= 1'b0;

		while (decoded.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Drove %0d header bytes (%0d from the directed table) with random idling.",
			beats_in, $size(DIRECTED));
		$display("Checked %0d decoded headers, %0d of them with an error status.",
			headers_checked, error_headers);
		if (mismatches == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule

>>> mpeg_audio_header_decoder.f
+incdir+rtl/core
rtl/core/mahd_pkg.sv
rtl/core/mahd_ctrl.sv
rtl/core/mahd_dp.sv
rtl/core/mpeg_audio_header_decoder.sv
tb/sv/mpeg_audio_header_decoder_test.sv
